// ----- rtl/lpm_pkg.sv -----
// Shared types and constants for the longest prefix match route table.
package lpm_pkg;

   localparam int SLOT_W = 4;
   localparam int PORT_W = 4;
   localparam int ADDR_W = 32;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_LOOKUP = 1'b1;

   typedef struct packed {
      logic              action;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] route_prefix_in;
      logic [ADDR_W-1:0] route_mask_in;
      logic [PORT_W-1:0] route_port_in;
      logic              route_enable;
      logic [ADDR_W-1:0] lookup_address;
   } lpm_req_type;

   typedef struct packed {
      logic              hit;
      logic [PORT_W-1:0] out_port;
      logic [SLOT_W-1:0] match_slot;
      logic [ADDR_W-1:0] match_mask;
   } lpm_rsp_type;

   // Route data broadcast to every cell; only the selected cell stores it.
   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [PORT_W-1:0] port;
      logic              enable;
   } lpm_write_type;

   // Search token passed from cell to cell with the best match so far.
   typedef struct packed {
      logic              active;
      logic [ADDR_W-1:0] addr;
      logic              found;
      logic [ADDR_W-1:0] mask;
      logic [SLOT_W-1:0] slot;
      logic [PORT_W-1:0] port;
   } lpm_search_type;

   typedef enum logic {
      LPM_IDLE,
      LPM_SEARCH
   } lpm_state_type;

endpackage

// ----- rtl/lpm_cell.sv -----
// One route table cell: holds a single route entry and updates the passing search token.
module lpm_cell
   import lpm_pkg::*;
#(
   parameter int CELL_ID = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_sel,
   input  lpm_write_type  wr_data,
   input  lpm_search_type search_in,
   output lpm_search_type search_out
);

   logic [ADDR_W-1:0] prefix_ff;
   logic [ADDR_W-1:0] mask_ff;
   logic [PORT_W-1:0] port_ff;
   logic              valid_ff;
   lpm_search_type    search_ff;
   lpm_search_type    search_in_q;

   logic match;
   logic better;

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         prefix_ff <= wr_data.prefix;
         mask_ff   <= wr_data.mask;
         port_ff   <= wr_data.port;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_sel) begin
         valid_ff <= wr_data.enable;
      end
   end

   assign match  = valid_ff && ((search_in.addr & mask_ff) == (prefix_ff & mask_ff));
   // Cells are visited in ascending slot order, so a strict compare keeps the
   // lowest slot when masks tie.
   assign better = match && (!search_in.found || (mask_ff > search_in.mask));

   always_comb begin
      search_in_q = search_in;
      if (better) begin
         search_in_q.found = 1'b1;
         search_in_q.mask  = mask_ff;
         search_in_q.slot  = SLOT_W'(CELL_ID);
         search_in_q.port  = port_ff;
      end
   end

   // Only the token's active bit is reset; the data fields follow it.
   always_ff @(posedge clock) begin
      search_ff.addr  <= search_in_q.addr;
      search_ff.found <= search_in_q.found;
      search_ff.mask  <= search_in_q.mask;
      search_ff.slot  <= search_in_q.slot;
      search_ff.port  <= search_in_q.port;
      if (reset) begin
         search_ff.active <= 1'b0;
      end else begin
         search_ff.active <= search_in.active;
      end
   end

   assign search_out = search_ff;

endmodule

// ----- rtl/longest_prefix_match_lookup.sv -----
// Top level of the IPv4 longest prefix match route table.
// A route write is stored, and its (all-zero) response registered, at the edge
// that accepts the request. A lookup request enters a chain of ROUTE_SLOTS
// cells, one route entry per cell, and advances one cell per cycle carrying the
// best match found so far; its response is registered from the token that leaves
// the last cell. The chain holds one lookup at a time, so no request is accepted
// until that lookup's response is registered. Lookups and writes are accepted only
// while the response register is free or being drained; writes then once per cycle.
// Slot numbers are four bits wide, so only the first sixteen slots can be written.
// After reset all routes are invalid.
module longest_prefix_match_lookup
   import lpm_pkg::*;
#(
   parameter int ROUTE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lpm_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lpm_rsp_type rsp_payload
);

   lpm_state_type  state_ff;
   lpm_state_type  state_in;
   lpm_search_type chain [0:ROUTE_SLOTS];
   lpm_write_type  wr_data;
   logic [ROUTE_SLOTS-1:0] wr_sel;
   logic [ROUTE_SLOTS-1:0] token_active;

   logic        rsp_valid_ff;
   lpm_rsp_type rsp_payload_ff;
   logic        rsp_free;
   logic        req_fire;
   logic        wr_fire;
   logic        lookup_fire;
   logic        chain_done;
   lpm_search_type last_token;

   assign last_token  = chain[ROUTE_SLOTS];
   assign chain_done  = last_token.active;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign req_fire    = req_valid && !req_stall;
   assign wr_fire     = req_fire && (req_payload.action == ACTION_WRITE);
   assign lookup_fire = req_fire && (req_payload.action == ACTION_LOOKUP);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LPM_IDLE: begin
            if (lookup_fire) begin
               state_in = LPM_SEARCH;
            end
         end
         LPM_SEARCH: begin
            if (chain_done) begin
               state_in = LPM_IDLE;
            end
         end
         default: state_in = LPM_IDLE;
      endcase
   end

   // Outputs of the controller.
   always_comb begin
      unique case (state_ff)
         LPM_IDLE:   req_stall = !rsp_free;
         LPM_SEARCH: req_stall = 1'b1;
         default:    req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LPM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign wr_data.prefix = req_payload.route_prefix_in;
   assign wr_data.mask   = req_payload.route_mask_in;
   assign wr_data.port   = req_payload.route_port_in;
   assign wr_data.enable = req_payload.route_enable;

   always_comb begin
      chain[0]        = '0;
      chain[0].active = lookup_fire;
      chain[0].addr   = req_payload.lookup_address;
   end

   genvar i;
   generate
      for (i = 0; i < ROUTE_SLOTS; i++) begin : g_cell
         assign wr_sel[i]       = wr_fire && (32'(req_payload.slot) == 32'(i));
         assign token_active[i] = chain[i+1].active;

         lpm_cell #(
            .CELL_ID (i)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .wr_sel     (wr_sel[i]),
            .wr_data    (wr_data),
            .search_in  (chain[i]),
            .search_out (chain[i+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (wr_fire || chain_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         rsp_payload_ff <= '0;
      end else if (chain_done) begin
         if (last_token.found) begin
            rsp_payload_ff.hit        <= 1'b1;
            rsp_payload_ff.out_port   <= last_token.port;
            rsp_payload_ff.match_slot <= last_token.slot;
            rsp_payload_ff.match_mask <= last_token.mask;
         end else begin
            rsp_payload_ff <= '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Only one lookup may travel through the chain at a time.
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_active))
      else $error("more than one lookup token in the cell chain");

   // A token in the chain implies the controller is searching.
   a_token_in_search: assert property (@(posedge clock) disable iff (reset)
      (token_active != '0) |-> (state_ff == LPM_SEARCH))
      else $error("lookup token present while controller is idle");

   // A finished lookup never overwrites a response still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      chain_done |-> rsp_free)
      else $error("lookup finished while response register was blocked");

   // A miss or write response carries all-zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.hit) |->
         (rsp_payload_ff.out_port == '0 && rsp_payload_ff.match_slot == '0 &&
          rsp_payload_ff.match_mask == '0))
      else $error("miss response with nonzero fields");

endmodule

// ----- tb/tb_longest_prefix_match_lookup.sv -----
// Self-checking testbench for the longest prefix match route table.
`timescale 1ns / 1ps

module tb_longest_prefix_match_lookup;
   import lpm_pkg::*;

   localparam int ROUTE_SLOTS  = 16;
   localparam int IDLE_LIMIT   = 3000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int PRINT_LIMIT  = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   lpm_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   lpm_rsp_type rsp_payload;

   longest_prefix_match_lookup #(
      .ROUTE_SLOTS(ROUTE_SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // Route table as the checker sees it.
   logic [ADDR_W-1:0] route_prefix [ROUTE_SLOTS];
   logic [ADDR_W-1:0] route_mask [ROUTE_SLOTS];
   logic [PORT_W-1:0] route_port [ROUTE_SLOTS];
   logic              route_valid [ROUTE_SLOTS] = '{default: 1'b0};

   // Routes as the generator last wrote them, used to aim lookups at real entries.
   logic [ADDR_W-1:0] hint_prefix [ROUTE_SLOTS] = '{default: '0};
   logic [ADDR_W-1:0] hint_mask [ROUTE_SLOTS] = '{default: '0};

   lpm_req_type req_pending_q[$];
   lpm_rsp_type rsp_expected_q[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int error_count = 0;
   int idle_cycles = 0;
   bit req_taken = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic lpm_rsp_type route_table_step(input lpm_req_type r);
      lpm_rsp_type res;
      res = '0;
      if (r.action == ACTION_WRITE) begin
         if (r.slot < ROUTE_SLOTS) begin
            route_prefix[r.slot] = r.route_prefix_in;
            route_mask[r.slot]   = r.route_mask_in;
            route_port[r.slot]   = r.route_port_in;
            route_valid[r.slot]  = r.route_enable;
         end
      end else begin
         // Strictly larger mask replaces the best so far, so ties keep the lowest slot.
         for (int i = 0; i < ROUTE_SLOTS; i++) begin
            if (route_valid[i]
                && ((r.lookup_address & route_mask[i]) == (route_prefix[i] & route_mask[i]))
                && (!res.hit || route_mask[i] > res.match_mask)) begin
               res.hit        = 1'b1;
               res.out_port   = route_port[i];
               res.match_slot = SLOT_W'(i);
               res.match_mask = route_mask[i];
            end
         end
      end
      return res;
   endfunction

   function automatic lpm_req_type random_request();
      lpm_req_type r;
      r.action          = 1'($urandom);
      r.slot            = SLOT_W'($urandom);
      r.route_prefix_in = $urandom;
      r.route_mask_in   = $urandom;
      r.route_port_in   = PORT_W'($urandom);
      r.route_enable    = 1'($urandom);
      r.lookup_address  = $urandom;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   task automatic queue_write(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] prefix,
                              input logic [ADDR_W-1:0] mask, input logic [PORT_W-1:0] port,
                              input logic enable);
      lpm_req_type r;
      r = random_request();
      r.action          = ACTION_WRITE;
      r.slot            = slot;
      r.route_prefix_in = prefix;
      r.route_mask_in   = mask;
      r.route_port_in   = port;
      r.route_enable    = enable;
      hint_prefix[slot] = prefix;
      hint_mask[slot]   = mask;
      req_pending_q.push_back(r);
   endtask

   task automatic queue_lookup(input logic [ADDR_W-1:0] addr);
      lpm_req_type r;
      r = random_request();
      r.action         = ACTION_LOOKUP;
      r.lookup_address = addr;
      req_pending_q.push_back(r);
   endtask

   task automatic queue_random_items(input int count);
      int                len;
      int                s;
      logic [ADDR_W-1:0] m;
      logic [ADDR_W-1:0] addr;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 35) begin
            len = $urandom_range(32);
            m = (len == 0) ? '0 : ~32'h0 << (32 - len);
            case ($urandom_range(9))
               0: m = $urandom;
               1: m = '0;
               2: m = '1;
               default: ;
            endcase
            addr = $urandom;
            // Copy an existing route now and then so that equal masks compete.
            if ($urandom_range(99) < 15) begin
               s = $urandom_range(ROUTE_SLOTS - 1);
               addr = hint_prefix[s];
               m = hint_mask[s];
            end
            queue_write(SLOT_W'($urandom), addr, m, PORT_W'($urandom),
                        $urandom_range(99) < 85);
         end else begin
            s = $urandom_range(ROUTE_SLOTS - 1);
            if ($urandom_range(99) < 75)
               addr = (hint_prefix[s] & hint_mask[s]) | ($urandom & ~hint_mask[s]);
            else
               addr = $urandom;
            if ($urandom_range(99) < 15)
               addr = addr ^ (32'h1 << $urandom_range(31));
            queue_lookup(addr);
         end
      end
   endtask

   task automatic wait_idle();
      while (req_pending_q.size() != 0 || req_valid)
         @(posedge clock);
      while (rsp_expected_q.size() != 0)
         @(posedge clock);
   endtask

   // Request driver: a stalled request holds its payload until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= req_pending_q.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure, with an optional long hold-off.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: checks responses, predicts accepted requests, and runs the watchdog.
   always @(posedge clock) begin
      lpm_rsp_type want;
      bit          moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (rsp_expected_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_payload.match_mask, '0);
            end else begin
               want = rsp_expected_q.pop_front();
               if (rsp_payload.hit !== want.hit)
                  report_mismatch("hit", rsp_payload.hit, want.hit);
               if (rsp_payload.out_port !== want.out_port)
                  report_mismatch("out_port", rsp_payload.out_port, want.out_port);
               if (rsp_payload.match_slot !== want.match_slot)
                  report_mismatch("match_slot", rsp_payload.match_slot, want.match_slot);
               if (rsp_payload.match_mask !== want.match_mask)
                  report_mismatch("match_mask", rsp_payload.match_mask, want.match_mask);
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            rsp_expected_q.push_back(route_table_step(req_payload));
            req_taken = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 13;
      recv_idle_pct = 54;
      queue_lookup(32'h0000_0000);
      queue_lookup(32'hFFFF_FFFF);
      // Default route in slot 0 catches everything.
      queue_write(4'd0, 32'h1234_5678, 32'h0000_0000, 4'd4, 1'b1);
      queue_lookup(32'hC0A8_0101);
      queue_write(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1);
      queue_lookup(32'hFFFF_FFFF);
      queue_lookup(32'hFFFF_FFFE);
      // Two equal /8 routes: the lower slot must win.
      queue_write(4'd5, 32'h0A00_0000, 32'hFF00_0000, 4'd7, 1'b1);
      queue_write(4'd3, 32'h0A00_0000, 32'hFF00_0000, 4'd2, 1'b1);
      queue_lookup(32'h0A01_0203);
      // A scattered mask ranks by its numeric value.
      queue_write(4'd7, 32'h0A00_00FF, 32'h0F00_00FF, 4'd9, 1'b1);
      queue_lookup(32'h0A00_00FF);
      queue_lookup(32'h1A00_00FF);
      // A disabled write removes the route but still overwrites its contents.
      queue_write(4'd3, 32'h0A00_0000, 32'hFF00_0000, 4'd2, 1'b0);
      queue_lookup(32'h0A01_0203);
      queue_write(4'd12, 32'h0000_0000, 32'h0000_0000, 4'd0, 1'b1);
      queue_lookup(32'h7777_7777);
      queue_write(4'd0, 32'h0000_0000, 32'h0000_0000, 4'd4, 1'b0);
      queue_lookup(32'h7777_7777);
      queue_write(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b0);
      queue_lookup(32'hFFFF_FFFF);
      queue_random_items(440);
      wait_idle();

      send_idle_pct = 54;
      recv_idle_pct = 13;
      queue_random_items(445);
      wait_idle();

      // No idling, but the response side holds off long enough to back up the input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = LONG_HOLD;
      queue_random_items(445);
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
